[rtl/lcf_pkg.sv]
// shared types and constants for the label contour follower
// no dependencies; compiled first
`default_nettype none

package lcf_pkg;

	localparam int unsigned DEF_MAP_DEPTH  = 65536;
	localparam int unsigned DEF_LABEL_BITS = 16;

	localparam int unsigned KIND_W     = 2;
	localparam int unsigned PIX_W      = 16;
	localparam int unsigned LAB_W      = 16;
	localparam int unsigned WIDTH_W    = 13;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned PROBE_W    = 3;

	typedef logic [KIND_W-1:0]     kind_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [PROBE_W-1:0]    probe_t;

	localparam kind_t KIND_WRITE = 2'd0;
	localparam kind_t KIND_START = 2'd1;
	localparam kind_t KIND_STEP  = 2'd2;

	localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_idx_t REG_GROUPED_CODE = 2'd1;

	localparam logic [WIDTH_W-1:0]    IMAGE_WIDTH_RST  = 13'd256;
	localparam logic [CFG_DATA_W-1:0] GROUPED_CODE_RST = 16'hFFFF;

	// neighbor probe order
	localparam probe_t PRB_RIGHT      = 3'd0;
	localparam probe_t PRB_LEFT       = 3'd1;
	localparam probe_t PRB_DOWN       = 3'd2;
	localparam probe_t PRB_UP         = 3'd3;
	localparam probe_t PRB_DOWN_RIGHT = 3'd4;
	localparam probe_t PRB_DOWN_LEFT  = 3'd5;
	localparam probe_t PRB_UP_RIGHT   = 3'd6;
	localparam probe_t PRB_UP_LEFT    = 3'd7;

endpackage

`default_nettype wire

[rtl/lcf_in_if.sv]
// input item channel of the label contour follower
// depends on lcf_pkg
`default_nettype none

interface lcf_in_if import lcf_pkg::*; ();
	logic              valid;
	logic              ready;
	kind_t             kind;
	logic [PIX_W-1:0]  pixel_index;
	logic [LAB_W-1:0]  label_value;

	modport source (output valid, kind, pixel_index, label_value, input ready);
	modport sink   (input valid, kind, pixel_index, label_value, output ready);
endinterface

`default_nettype wire

[rtl/lcf_out_if.sv]
// result channel of the label contour follower
// depends on lcf_pkg
`default_nettype none

interface lcf_out_if import lcf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  contour_pixel;
	logic              found;

	modport source (output valid, contour_pixel, found, input ready);
	modport sink   (input valid, contour_pixel, found, output ready);
endinterface

`default_nettype wire

[rtl/lcf_cfg_if.sv]
// configuration write channel of the label contour follower
// depends on lcf_pkg
`default_nettype none

interface lcf_cfg_if import lcf_pkg::*; ();
	logic                   valid;
	logic                   ready;
	cfg_idx_t               index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/label_contour_follower_top.sv]
// Label contour follower, 8-connected trace over a stored label map.
// Channels: item (sink) takes kind / pixel_index / label_value; result (source)
// returns contour_pixel / found, exactly one result per item; cfg (sink) writes
// image_width (index 0) and grouped_code (index 1), always ready; the user must use it
// only while idle, since the block itself does not enforce it. A write, a start, an
// idle step or an unused kind goes from the idle state straight to the done state. An
// active step probes the neighbors in turn: each neighbor address goes through the one
// shared adder, then the single read port of the label map; a probe outside the map
// skips the read. A step ends at the first match, or after all eight probes if none.
// One item is in flight at a time; item.ready is high only while the sequencer
// waits for work, and the result sits in an output register while the next item
// is taken, so a new item need not wait for the receiver to take the last result.
// If the receiver stalls, the next finished result waits in the
// sequencer until the output register drains.
// Reset clears the sequencer, the trace state and the registers (width 256,
// grouped code all ones). The label map is not cleared: entries must be written
// before a trace reads them.
// depends on lcf_pkg, lcf_in_if, lcf_out_if, lcf_cfg_if, lcf_label_mem, lcf_probe_unit
`default_nettype none

module label_contour_follower_top import lcf_pkg::*; #(
	parameter int unsigned MAP_DEPTH  = DEF_MAP_DEPTH,
	parameter int unsigned LABEL_BITS = DEF_LABEL_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lcf_in_if.sink     item,
	lcf_out_if.source  result,
	lcf_cfg_if.sink    cfg
);

	localparam int unsigned ADDR_W = $clog2(MAP_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ADDR = 4'b0010,
		S_CMP  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [WIDTH_W-1:0]      width_q;
	logic [LABEL_BITS-1:0]   grouped_q;
	logic [ADDR_W-1:0]       cur_q;
	logic [LABEL_BITS-1:0]   lab_q;
	logic                    active_q;
	probe_t                  probe_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [PIX_W-1:0]        pend_pix_q;
	logic                    pend_found_q;
	logic                    out_valid_q;
	logic [PIX_W-1:0]        out_pix_q;
	logic                    out_found_q;

	logic                    item_xfer;
	logic                    cfg_xfer;
	logic                    pix_ok;
	logic [ADDR_W+PIX_W-1:0] pix_ext;
	logic [ADDR_W-1:0]       pix_addr;
	logic [LABEL_BITS+LAB_W-1:0] lab_ext;
	logic [LABEL_BITS-1:0]   in_label;
	logic [LABEL_BITS+CFG_DATA_W-1:0] gc_ext;
	logic [PIX_W+ADDR_W-1:0] hit_ext;
	logic [PIX_W-1:0]        hit_pix;
	logic [PIX_W+ADDR_W-1:0] st_ext;
	logic [PIX_W-1:0]        start_pix;

	logic [ADDR_W-1:0]       prb_addr;
	logic                    prb_in_range;
	logic                    mem_wr_en;
	logic [ADDR_W-1:0]       mem_wr_addr;
	logic [LABEL_BITS-1:0]   mem_wr_data;
	logic                    mem_rd_en;
	logic [LABEL_BITS-1:0]   mem_rd_data;
	logic                    hit;
	logic                    out_free;

	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign item_xfer  = item.valid && item.ready;
	assign cfg_xfer   = cfg.valid && cfg.ready;

	// resize fixed-width fields to the map geometry
	assign pix_ext   = {{ADDR_W{1'b0}}, item.pixel_index};
	assign pix_addr  = pix_ext[ADDR_W-1:0];
	assign pix_ok    = (32'(item.pixel_index) < 32'(MAP_DEPTH));
	assign lab_ext   = {{LABEL_BITS{1'b0}}, item.label_value};
	assign in_label  = lab_ext[LABEL_BITS-1:0];
	assign gc_ext    = {{LABEL_BITS{1'b0}}, cfg.data};
	assign hit_ext   = {{PIX_W{1'b0}}, addr_q};
	assign hit_pix   = hit_ext[PIX_W-1:0];
	assign st_ext    = {{PIX_W{1'b0}}, pix_addr};
	assign start_pix = st_ext[PIX_W-1:0];

	assign hit      = (mem_rd_data == lab_q);
	assign out_free = !out_valid_q || result.ready;

	lcf_probe_unit #(
		.MAP_DEPTH (MAP_DEPTH),
		.ADDR_W    (ADDR_W)
	) u_probe (
		.cur      (cur_q),
		.width    (width_q),
		.sel      (probe_q),
		.addr     (prb_addr),
		.in_range (prb_in_range)
	);

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = pix_addr;
		mem_wr_data = in_label;
		if (state_q == S_IDLE && item_xfer && pix_ok) begin
			if (item.kind == KIND_WRITE) begin
				mem_wr_en = 1'b1;
			end else if (item.kind == KIND_START) begin
				mem_wr_en   = 1'b1;
				mem_wr_data = grouped_q;
			end
		end else if (state_q == S_CMP && hit) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = addr_q;
			mem_wr_data = grouped_q;
		end
	end

	assign mem_rd_en = (state_q == S_ADDR) && prb_in_range;

	lcf_label_mem #(
		.DEPTH  (MAP_DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (LABEL_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (prb_addr),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= IMAGE_WIDTH_RST;
			grouped_q <= '1;
		end else if (cfg_xfer) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:  width_q   <= cfg.data[WIDTH_W-1:0];
				REG_GROUPED_CODE: grouped_q <= gc_ext[LABEL_BITS-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			lab_q        <= '0;
			active_q     <= 1'b0;
			probe_q      <= PRB_RIGHT;
			addr_q       <= '0;
			pend_pix_q   <= '0;
			pend_found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_xfer) begin
						case (item.kind)
							KIND_START: begin
								state_q <= S_DONE;
								if (pix_ok) begin
									cur_q        <= pix_addr;
									lab_q        <= in_label;
									active_q     <= 1'b1;
									pend_pix_q   <= start_pix;
									pend_found_q <= 1'b1;
								end else begin
									active_q     <= 1'b0;
									pend_pix_q   <= '0;
									pend_found_q <= 1'b0;
								end
							end
							KIND_STEP: begin
								pend_pix_q   <= '0;
								pend_found_q <= 1'b0;
								if (active_q) begin
									probe_q <= PRB_RIGHT;
									state_q <= S_ADDR;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								pend_pix_q   <= '0;
								pend_found_q <= 1'b0;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_ADDR: begin
					addr_q <= prb_addr;
					if (prb_in_range) begin
						state_q <= S_CMP;
					end else if (probe_q == PRB_UP_LEFT) begin
						active_q <= 1'b0;
						state_q  <= S_DONE;
					end else begin
						probe_q <= probe_q + 1'b1;
					end
				end
				S_CMP: begin
					if (hit) begin
						cur_q        <= addr_q;
						pend_pix_q   <= hit_pix;
						pend_found_q <= 1'b1;
						state_q      <= S_DONE;
					end else if (probe_q == PRB_UP_LEFT) begin
						active_q <= 1'b0;
						state_q  <= S_DONE;
					end else begin
						probe_q <= probe_q + 1'b1;
						state_q <= S_ADDR;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register, loaded once the previous result has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_pix_q   <= pend_pix_q;
			out_found_q <= pend_found_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.contour_pixel = out_pix_q;
	assign result.found         = out_found_q;

endmodule

`default_nettype wire

[rtl/lcf_label_mem.sv]
// label map storage: one write port, one read port with registered read data
// no package dependencies
`default_nettype none

module lcf_label_mem #(
	parameter int unsigned DEPTH  = 65536,
	parameter int unsigned ADDR_W = 16,
	parameter int unsigned DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/lcf_probe_unit.sv]
// shared neighbor address unit: current pixel plus offset of one probe, with map bounds check
// depends on lcf_pkg
`default_nettype none

module lcf_probe_unit import lcf_pkg::*; #(
	parameter int unsigned MAP_DEPTH = DEF_MAP_DEPTH,
	parameter int unsigned ADDR_W    = 16
) (
	input  wire logic [ADDR_W-1:0]  cur,
	input  wire logic [WIDTH_W-1:0] width,
	input  wire probe_t             sel,
	output      logic [ADDR_W-1:0]  addr,
	output      logic               in_range
);

	localparam int unsigned SUM_W = ((ADDR_W > WIDTH_W) ? ADDR_W : WIDTH_W) + 2;
	localparam logic signed [SUM_W-1:0] LIMIT = SUM_W'(MAP_DEPTH);
	localparam logic signed [SUM_W-1:0] ONE   = SUM_W'(1);

	logic signed [SUM_W-1:0] base;
	logic signed [SUM_W-1:0] stride;
	logic signed [SUM_W-1:0] vert;
	logic signed [SUM_W-1:0] horz;
	logic signed [SUM_W-1:0] sum;

	assign base   = signed'({{(SUM_W-ADDR_W){1'b0}}, cur});
	assign stride = signed'({{(SUM_W-WIDTH_W){1'b0}}, width});

	always_comb begin
		case (sel)
			PRB_RIGHT:      begin vert = '0;      horz = ONE;  end
			PRB_LEFT:       begin vert = '0;      horz = -ONE; end
			PRB_DOWN:       begin vert = stride;  horz = '0;   end
			PRB_UP:         begin vert = -stride; horz = '0;   end
			PRB_DOWN_RIGHT: begin vert = stride;  horz = ONE;  end
			PRB_DOWN_LEFT:  begin vert = stride;  horz = -ONE; end
			PRB_UP_RIGHT:   begin vert = -stride; horz = ONE;  end
			PRB_UP_LEFT:    begin vert = -stride; horz = -ONE; end
			default:        begin vert = '0;      horz = '0;   end
		endcase
	end

	assign sum      = base + vert + horz;
	assign addr     = sum[ADDR_W-1:0];
	assign in_range = !sum[SUM_W-1] && (sum < LIMIT);

endmodule

`default_nettype wire

[tb/label_contour_follower_top_test.sv]
// testbench for label_contour_follower_top: directed and random label writes and traces,
// each result checked against a predicted map and trace state held in a scoreboard class
// depends on lcf_pkg, lcf_in_if, lcf_out_if, lcf_cfg_if and the block itself
`default_nettype none

module label_contour_follower_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lcf_pkg::*;

	localparam kind_t KIND_UNUSED    = 2'd3;
	localparam int    MAP_SIZE       = DEF_MAP_DEPTH;
	localparam int    WATCHDOG_LIMIT = 4000;
	localparam int    DRAIN_CYCLES   = 24;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             found;
	} contour_hit_t;

	// offset of a neighbor in probe order for a given row stride
	function automatic int nb_offset(probe_t k, int w);
		case (k)
			PRB_RIGHT:      return 1;
			PRB_LEFT:       return -1;
			PRB_DOWN:       return w;
			PRB_UP:         return -w;
			PRB_DOWN_RIGHT: return w + 1;
			PRB_DOWN_LEFT:  return w - 1;
			PRB_UP_RIGHT:   return -w + 1;
			default:        return -w - 1;
		endcase
	endfunction

	class contour_scoreboard;
		bit [LAB_W-1:0]   label_mem [MAP_SIZE];
		bit               written [MAP_SIZE];
		bit [PIX_W-1:0]   cur_pix;
		bit [LAB_W-1:0]   follow_lab;
		bit               tracing;
		bit [WIDTH_W-1:0] img_width = IMAGE_WIDTH_RST;
		bit [LAB_W-1:0]   grp_code = GROUPED_CODE_RST[LAB_W-1:0];
		contour_hit_t     due_q[$];
		int               errors;

		function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_IMAGE_WIDTH:  img_width = data[WIDTH_W-1:0];
				REG_GROUPED_CODE: grp_code = data[LAB_W-1:0];
				default: ;
			endcase
		endfunction

		function int neighbor(int k);
			return int'(cur_pix) + nb_offset(probe_t'(k), int'(img_width));
		endfunction

		// first map entry the next step would read before it has been written, or -1
		function int first_unwritten_probe();
			int p;
			if (!tracing)
				return -1;
			for (int k = 0; k < 8; k++) begin
				p = neighbor(k);
				if (p >= 0 && p < MAP_SIZE) begin
					if (!written[p])
						return p;
					if (label_mem[p] == follow_lab)
						return -1;
				end
			end
			return -1;
		endfunction

		function void note_item(kind_t kind, logic [PIX_W-1:0] pix, logic [LAB_W-1:0] lab);
			contour_hit_t hit;
			int p;
			hit = '0;
			case (kind)
				KIND_WRITE: begin
					label_mem[pix] = lab;
					written[pix] = 1'b1;
				end
				KIND_START: begin
					cur_pix = pix;
					follow_lab = lab;
					label_mem[pix] = grp_code;
					written[pix] = 1'b1;
					tracing = 1'b1;
					hit.pixel = pix;
					hit.found = 1'b1;
				end
				KIND_STEP: if (tracing) begin
					tracing = 1'b0;
					for (int k = 0; k < 8 && !hit.found; k++) begin
						p = neighbor(k);
						if (p >= 0 && p < MAP_SIZE && label_mem[p] == follow_lab) begin
							label_mem[p] = grp_code;
							cur_pix = p[PIX_W-1:0];
							tracing = 1'b1;
							hit.pixel = p[PIX_W-1:0];
							hit.found = 1'b1;
						end
					end
				end
				default: ;
			endcase
			due_q.push_back(hit);
		endfunction

		function void check_result(logic [PIX_W-1:0] pix, logic found);
			contour_hit_t want;
			if (due_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: contour_pixel %h found %b",
					$time, pix, found);
				return;
			end
			want = due_q.pop_front();
			if (found !== want.found) begin
				errors++;
				$display("%0t: found expected %b actual %b", $time, want.found, found);
			end
			if (pix !== want.pixel) begin
				errors++;
				$display("%0t: contour_pixel expected %h actual %h", $time, want.pixel, pix);
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;
	int   items_sent = 0;
	int   quiet = 0;
	contour_scoreboard sb;

	lcf_in_if  item_ch ();
	lcf_out_if res_ch ();
	lcf_cfg_if cfg_ch ();

	label_contour_follower_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #1 clk = ~clk;

	// receiver side: random stalls except in the calm phase
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= calm || ($urandom_range(99) >= 28);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.contour_pixel, res_ch.found);
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("label_contour_follower_top_test: errors");
				$finish;
			end
		end
	end

	// entered and left at a falling edge; valid stays high for a following item
	task automatic send_item(kind_t kind, logic [PIX_W-1:0] pix, logic [LAB_W-1:0] lab);
		while (!calm && $urandom_range(99) < 28) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= kind;
		item_ch.pixel_index <= pix;
		item_ch.label_value <= lab;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(kind, pix, lab);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [LAB_W-1:0] fill_label();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			return sb.follow_lab;
		if (pick < 40)
			return sb.grp_code;
		return LAB_W'($urandom_range(0, 65535));
	endfunction

	// write any neighbor the step would read unwritten, then step
	task automatic trace_step();
		int gap;
		gap = sb.first_unwritten_probe();
		while (gap >= 0) begin
			send_item(KIND_WRITE, PIX_W'(gap), fill_label());
			gap = sb.first_unwritten_probe();
		end
		send_item(KIND_STEP, PIX_W'($urandom_range(0, 65535)), LAB_W'($urandom_range(0, 65535)));
	endtask

	task automatic follow_trace(int cap);
		int n;
		n = 0;
		while (sb.tracing && n < cap) begin
			trace_step();
			n++;
		end
	endtask

	task automatic run_contour();
		int base;
		int p;
		int q;
		int len;
		int cap;
		int steps;
		int pick;
		logic [LAB_W-1:0] lab;
		pick = $urandom_range(99);
		if (pick < 10)
			base = $urandom_range(0, 40);
		else if (pick < 20)
			base = MAP_SIZE - 1 - $urandom_range(0, 40);
		else
			base = $urandom_range(0, MAP_SIZE - 1);
		lab = ($urandom_range(99) < 15) ? sb.grp_code : LAB_W'($urandom_range(0, 65535));
		len = $urandom_range(0, 8);
		p = base;
		// lay a short chain of the label so the trace has somewhere to go
		for (int j = 0; j < len; j++) begin
			q = p + nb_offset(probe_t'($urandom_range(0, 7)), int'(sb.img_width));
			if (q >= 0 && q < MAP_SIZE)
				p = q;
			send_item(KIND_WRITE, PIX_W'(p), lab);
		end
		send_item(KIND_START, PIX_W'(base), lab);
		cap = ($urandom_range(99) < 10) ? 40 : $urandom_range(1, 12);
		steps = 0;
		while (sb.tracing && steps < cap) begin
			pick = $urandom_range(99);
			if (pick < 4)
				send_item(KIND_WRITE, PIX_W'($urandom_range(0, 65535)),
					LAB_W'($urandom_range(0, 65535)));
			else if (pick < 7)
				send_item(KIND_START, sb.cur_pix, sb.follow_lab);
			trace_step();
			steps++;
		end
		if ($urandom_range(99) < 30)
			trace_step();
	endtask

	task automatic noise_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35)
			send_item(KIND_UNUSED, PIX_W'($urandom_range(0, 65535)),
				LAB_W'($urandom_range(0, 65535)));
		else if (pick < 70)
			send_item(KIND_WRITE, PIX_W'($urandom_range(0, 65535)),
				LAB_W'($urandom_range(0, 65535)));
		else
			trace_step();
	endtask

	task automatic run_phase(int w, logic [LAB_W-1:0] g, int quota, bit no_gaps);
		int start_cnt;
		wait_drained();
		cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
		cfg_write(REG_GROUPED_CODE, g);
		cfg_ch.valid <= 1'b0;
		calm = no_gaps;
		start_cnt = items_sent;
		while (items_sent - start_cnt < quota) begin
			if ($urandom_range(99) < 85)
				run_contour();
			else
				noise_item();
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_WRITE;
		item_ch.pixel_index = '0;
		item_ch.label_value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_IMAGE_WIDTH;
		cfg_ch.data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset register values in use: width 256, grouped code all ones
		send_item(KIND_STEP, 16'hFFFF, 16'hFFFF);
		send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF);
		send_item(KIND_WRITE, 16'h0000, 16'h0000);
		send_item(KIND_WRITE, 16'h0001, 16'h00AA);
		send_item(KIND_WRITE, 16'h0100, 16'h0000);
		// start at pixel zero: left and up probes fall below the map
		send_item(KIND_START, 16'h0000, 16'h0000);
		follow_trace(4);
		trace_step();
		// top corner, followed label equal to the grouped code
		send_item(KIND_WRITE, 16'hFFFF, 16'hFFFF);
		send_item(KIND_WRITE, 16'hFFFE, 16'h1234);
		send_item(KIND_WRITE, 16'hFEFF, 16'hFFFF);
		send_item(KIND_START, 16'hFFFF, 16'hFFFF);
		follow_trace(4);
		// restart while a trace may still run
		send_item(KIND_START, 16'hFFFE, 16'h1234);
		follow_trace(2);
		send_item(KIND_WRITE, 16'h5555, 16'hAAAA);
		send_item(KIND_WRITE, 16'hAAAA, 16'h5555);

		run_phase(1, 16'h0000, 200, 1'b0);
		run_phase(4096, 16'hA5A5, 200, 1'b1);
		run_phase(0, 16'h5A5A, 150, 1'b0);
		run_phase(8191, 16'hFFFF, 150, 1'b0);
		run_phase($urandom_range(2, 64), LAB_W'($urandom_range(0, 65535)), 250, 1'b0);
		run_phase(256, LAB_W'($urandom_range(0, 65535)), 250, 1'b0);
		run_phase($urandom_range(1, 4096), LAB_W'($urandom_range(0, 65535)), 150, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("label_contour_follower_top_test: clean");
		else
			$display("label_contour_follower_top_test: errors");
		$finish;
	end

endmodule

`default_nettype wire
